// ----- design/tpsd_pkg.sv -----
// Shared types and constants of the targa pixel stream decoder.
package tpsd_pkg;

  localparam int MAX_DIM_DEF = 2048;
  localparam int QUEUE_DEPTH = 4;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_PRESENT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RLE_ENABLE    = 2'd3;

  localparam logic [CFG_DATA_W-1:0] WIDTH_RESET  = 12'd4;
  localparam logic [CFG_DATA_W-1:0] HEIGHT_RESET = 12'd1;
  localparam int MIN_WIDTH = 4;

  localparam logic [7:0] OPAQUE_ALPHA = 8'd255;

  // Pixel bytes in stream order: blue, green, red, then alpha.
  localparam logic [1:0] PH_BLUE  = 2'd0;
  localparam logic [1:0] PH_GREEN = 2'd1;
  localparam logic [1:0] PH_RED   = 2'd2;
  localparam logic [1:0] PH_ALPHA = 2'd3;

  // One decoded pixel or run handed from the front end to the span generator.
  typedef struct packed {
    logic        restart;
    logic [7:0]  count;
    logic [23:0] colour;
    logic [7:0]  alpha;
  } cmd_t;

  typedef enum logic [0:0] {
    BK_IDLE = 1'b0,
    BK_EMIT = 1'b1
  } back_state_t;

endpackage

// ----- design/tpsd_queue.sv -----
// Small command queue between the byte front end and the span generator.
module tpsd_queue
  import tpsd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output cmd_t head_data
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;

  assign full       = (fill_r == CNT_W'(QUEUE_DEPTH));
  assign head_valid = (fill_r != '0);
  assign head_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      fill_nxt = fill_r + CNT_W'(1);
    end else if (pop && !push) begin
      fill_nxt = fill_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- design/tpsd_front.sv -----
// Byte front end: packet headers, byte phase and pixel assembly.
module tpsd_front
  import tpsd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_restart,
  input  logic       alpha_present,
  input  logic       rle_enable,
  input  logic       byte_take,
  input  logic [7:0] data_byte,
  input  logic       image_start,
  output logic       push,
  output cmd_t       push_data
);

  logic [1:0]  phase_r, phase_nxt;
  logic [7:0]  prem_r, prem_nxt;
  logic        isrun_r, isrun_nxt;
  logic [23:0] held_r, held_nxt;
  logic        pend_r, pend_nxt;

  logic [1:0]  phase_cur;
  logic [7:0]  prem_cur;
  logic        isrun_cur;
  logic [23:0] held_cur;
  logic        pixel;
  logic [7:0]  alpha_val;
  logic [7:0]  count_val;
  logic        restart_flag;

  always_comb begin
    // A restart takes effect before the byte is used.
    phase_cur    = image_start ? PH_BLUE : phase_r;
    prem_cur     = image_start ? 8'd0 : prem_r;
    isrun_cur    = image_start ? 1'b0 : isrun_r;
    held_cur     = image_start ? 24'd0 : held_r;
    phase_nxt    = phase_cur;
    prem_nxt     = prem_cur;
    isrun_nxt    = isrun_cur;
    held_nxt     = held_cur;
    pixel        = 1'b0;
    alpha_val    = data_byte;
    count_val    = 8'd0;
    restart_flag = image_start || pend_r;

    if (rle_enable && prem_cur == 8'd0) begin
      prem_nxt  = 8'd1 + {1'b0, data_byte[6:0]};
      isrun_nxt = data_byte[7];
      phase_nxt = PH_BLUE;
    end else begin
      case (phase_cur)
        PH_BLUE: begin
          held_nxt[7:0] = data_byte;
          phase_nxt     = PH_GREEN;
        end
        PH_GREEN: begin
          held_nxt[15:8] = data_byte;
          phase_nxt      = PH_RED;
        end
        PH_RED: begin
          held_nxt[23:16] = data_byte;
          if (alpha_present) begin
            phase_nxt = PH_ALPHA;
          end else begin
            phase_nxt = PH_BLUE;
            pixel     = 1'b1;
            alpha_val = OPAQUE_ALPHA;
          end
        end
        default: begin
          phase_nxt = PH_BLUE;
          pixel     = 1'b1;
        end
      endcase
      if (pixel) begin
        if (!rle_enable) begin
          count_val = 8'd1;
        end else if (isrun_cur) begin
          count_val = prem_cur;
          prem_nxt  = 8'd0;
        end else begin
          count_val = 8'd1;
          prem_nxt  = prem_cur - 8'd1;
        end
      end
    end

    push              = byte_take && (pixel || restart_flag);
    push_data.restart = restart_flag;
    push_data.count   = count_val;
    push_data.colour  = held_nxt;
    push_data.alpha   = alpha_val;
    pend_nxt          = push ? 1'b0 : pend_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_BLUE;
      prem_r  <= 8'd0;
      isrun_r <= 1'b0;
      pend_r  <= 1'b1;
    end else if (cfg_restart) begin
      phase_r <= PH_BLUE;
      prem_r  <= 8'd0;
      isrun_r <= 1'b0;
      pend_r  <= 1'b1;
    end else if (byte_take) begin
      phase_r <= phase_nxt;
      prem_r  <= prem_nxt;
      isrun_r <= isrun_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cfg_restart) begin
      held_r <= 24'd0;
    end else if (byte_take) begin
      held_r <= held_nxt;
    end
  end

endmodule

// ----- design/tpsd_back.sv -----
// Span generator: splits pixels and runs into spans at row ends.
module tpsd_back
  import tpsd_pkg::*;
#(
  parameter int MAX_DIM = MAX_DIM_DEF
)
(
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [$clog2(MAX_DIM+1)-1:0]     eff_width,
  input  logic [$clog2(MAX_DIM+1)-1:0]     eff_height,
  input  logic [2*$clog2(MAX_DIM+1)-1:0]   base_start,
  input  logic                             q_valid,
  input  cmd_t                             q_data,
  output logic                             q_pop,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [7:0]                       out_red,
  output logic [7:0]                       out_green,
  output logic [7:0]                       out_blue,
  output logic [7:0]                       out_alpha,
  output logic [10:0]                      out_row_index,
  output logic [10:0]                      out_first_column,
  output logic [7:0]                       out_span_length,
  output logic [21:0]                      out_pixel_address,
  output logic                             out_span_last,
  output logic                             out_image_done
);

  localparam int DIM_W = $clog2(MAX_DIM + 1);
  localparam int CW    = $clog2(MAX_DIM);
  localparam int AW    = 2 * DIM_W;
  localparam int LW    = (DIM_W > 8) ? DIM_W + 1 : 9;

  back_state_t state_r, state_nxt;

  logic          fin_r, fin_nxt;
  logic [7:0]    cnt_r;
  logic [23:0]   colour_r;
  logic [7:0]    alpha_r;
  logic [CW-1:0] row_r, row_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [AW-1:0] base_r, base_nxt;
  logic          ov_r;
  logic          emit;
  logic          go;

  logic [DIM_W-1:0] room;
  logic [7:0]       len;
  logic             wrap;
  logic             done;
  logic             last;

  // A popped command is dropped when its count is zero, or when the image is already complete and it is no restart.
  assign go = q_data.count != 8'd0 && (q_data.restart || !fin_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (q_valid && go) begin
          state_nxt = BK_EMIT;
        end
      end
      BK_EMIT: begin
        if (emit && last) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop = 1'b0;
    emit  = 1'b0;
    unique case (state_r)
      BK_IDLE: q_pop = q_valid;
      BK_EMIT: emit  = !ov_r || out_ready;
      default: begin
        q_pop = 1'b0;
        emit  = 1'b0;
      end
    endcase
  end

  always_comb begin
    room = eff_width - DIM_W'(col_r);
    len  = (LW'(cnt_r) < LW'(room)) ? cnt_r : 8'(room);
    wrap = (LW'(len) == LW'(room));
    done = wrap && (row_r == '0);
    last = (len == cnt_r) || done;

    fin_nxt  = fin_r;
    row_nxt  = row_r;
    col_nxt  = col_r;
    base_nxt = base_r;
    if (q_pop && q_data.restart) begin
      fin_nxt  = 1'b0;
      row_nxt  = CW'(eff_height - DIM_W'(1));
      col_nxt  = '0;
      base_nxt = base_start;
    end else if (emit) begin
      if (wrap) begin
        col_nxt = '0;
        if (done) begin
          fin_nxt = 1'b1;
        end else begin
          row_nxt  = row_r - CW'(1);
          base_nxt = base_r - AW'(eff_width);
        end
      end else begin
        col_nxt = CW'(LW'(col_r) + LW'(len));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      fin_r   <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fin_r   <= fin_nxt;
      if (emit) begin
        ov_r <= 1'b1;
      end else if (out_ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    row_r  <= row_nxt;
    col_r  <= col_nxt;
    base_r <= base_nxt;
    if (q_pop) begin
      cnt_r    <= q_data.count;
      colour_r <= q_data.colour;
      alpha_r  <= q_data.alpha;
    end else if (emit) begin
      cnt_r <= cnt_r - len;
    end
    if (emit) begin
      out_red           <= colour_r[23:16];
      out_green         <= colour_r[15:8];
      out_blue          <= colour_r[7:0];
      out_alpha         <= alpha_r;
      out_row_index     <= 11'(row_r);
      out_first_column  <= 11'(col_r);
      out_span_length   <= len;
      out_pixel_address <= 22'(base_r + AW'(col_r));
      out_span_last     <= last;
      out_image_done    <= done;
    end
  end

  assign out_valid = ov_r;

endmodule

// ----- design/tga_pixel_stream_decoder.sv -----
// Top level of the truecolor targa pixel stream decoder.
//
// Usage: after the header is parsed, write width, height, alpha_present and
// rle_enable through the cfg channel (index 0..3); every write restarts the
// image at column 0 of the bottom row. Then feed the pixel data one byte per
// in request; in_image_start on a byte restarts decoding before that byte.
// Each completed pixel or run leaves as one or more out requests, each a span
// of identical RGBA pixels inside one row, rows filled bottom to top.
// The front end takes one byte per cycle and hands decoded pixels and runs
// to the span generator through a four-entry queue. A pixel's first span
// passes through the queue, the generator's load step and its output
// register; spans then follow one per cycle while out_ready allows, with a
// load step for each queued command. Input stalls only while the queue is
// full, which happens when runs cross row ends or the receiver holds out_ready
// low; a stalled span stays in the output register and the generator waits.
// Bytes that arrive after the final pixel produce nothing until a restart.
// Reset (rst_n low, synchronous) loads width 4, height 1, 24-bit raw mode,
// empties the queue and drops any pending span.
module tga_pixel_stream_decoder
  import tpsd_pkg::*;
#(
  parameter int MAX_DIM = MAX_DIM_DEF
)
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_data_byte,
  input  logic                  in_image_start,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_red,
  output logic [7:0]            out_green,
  output logic [7:0]            out_blue,
  output logic [7:0]            out_alpha,
  output logic [10:0]           out_row_index,
  output logic [10:0]           out_first_column,
  output logic [7:0]            out_span_length,
  output logic [21:0]           out_pixel_address,
  output logic                  out_span_last,
  output logic                  out_image_done
);

  localparam int DIM_W = $clog2(MAX_DIM + 1);
  localparam int AW    = 2 * DIM_W;
  localparam int CMP_W = (DIM_W > CFG_DATA_W) ? DIM_W : CFG_DATA_W;

  logic [CFG_DATA_W-1:0] width_r;
  logic [CFG_DATA_W-1:0] height_r;
  logic                  alpha_present_r;
  logic                  rle_enable_r;
  logic                  cfg_write;

  logic [DIM_W-1:0] eff_width;
  logic [DIM_W-1:0] eff_height;
  logic [AW-1:0]    base_start_r;

  logic in_take;
  logic q_push;
  cmd_t q_push_data;
  logic q_full;
  logic q_pop;
  logic q_valid;
  cmd_t q_head;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r         <= WIDTH_RESET;
      height_r        <= HEIGHT_RESET;
      alpha_present_r <= 1'b0;
      rle_enable_r    <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:   width_r         <= cfg_data;
        REG_IMAGE_HEIGHT:  height_r        <= cfg_data;
        REG_ALPHA_PRESENT: alpha_present_r <= cfg_data[0];
        REG_RLE_ENABLE:    rle_enable_r    <= cfg_data[0];
        default:           width_r         <= width_r;
      endcase
    end
  end

  // Header dimensions are clamped to the supported range.
  always_comb begin
    if (CMP_W'(width_r) < CMP_W'(MIN_WIDTH)) begin
      eff_width = DIM_W'(MIN_WIDTH);
    end else if (CMP_W'(width_r) > CMP_W'(MAX_DIM)) begin
      eff_width = DIM_W'(MAX_DIM);
    end else begin
      eff_width = DIM_W'(width_r);
    end
    if (height_r == '0) begin
      eff_height = DIM_W'(1);
    end else if (CMP_W'(height_r) > CMP_W'(MAX_DIM)) begin
      eff_height = DIM_W'(MAX_DIM);
    end else begin
      eff_height = DIM_W'(height_r);
    end
  end

  // Start address of the bottom row, registered from the clamped dimensions.
  always_ff @(posedge clk) begin
    base_start_r <= AW'(eff_height - DIM_W'(1)) * AW'(eff_width);
  end

  assign in_ready = !q_full;
  assign in_take  = in_valid && in_ready;

  tpsd_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_restart   (cfg_write),
    .alpha_present (alpha_present_r),
    .rle_enable    (rle_enable_r),
    .byte_take     (in_take),
    .data_byte     (in_data_byte),
    .image_start   (in_image_start),
    .push          (q_push),
    .push_data     (q_push_data)
  );

  tpsd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_push_data),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_data  (q_head)
  );

  tpsd_back #(
    .MAX_DIM (MAX_DIM)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .eff_width         (eff_width),
    .eff_height        (eff_height),
    .base_start        (base_start_r),
    .q_valid           (q_valid),
    .q_data            (q_head),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_red           (out_red),
    .out_green         (out_green),
    .out_blue          (out_blue),
    .out_alpha         (out_alpha),
    .out_row_index     (out_row_index),
    .out_first_column  (out_first_column),
    .out_span_length   (out_span_length),
    .out_pixel_address (out_pixel_address),
    .out_span_last     (out_span_last),
    .out_image_done    (out_image_done)
  );

endmodule

// ----- design/tpsd_checker.sv -----
// Port-level checks for the targa pixel stream decoder, bound to the top level.
module tpsd_checker
  import tpsd_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  cfg_valid,
  input logic                  cfg_ready,
  input logic [CFG_IDX_W-1:0]  cfg_index,
  input logic [CFG_DATA_W-1:0] cfg_data,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic [7:0]            in_data_byte,
  input logic                  in_image_start,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [7:0]            out_red,
  input logic [7:0]            out_green,
  input logic [7:0]            out_blue,
  input logic [7:0]            out_alpha,
  input logic [10:0]           out_row_index,
  input logic [10:0]           out_first_column,
  input logic [7:0]            out_span_length,
  input logic [21:0]           out_pixel_address,
  input logic                  out_span_last,
  input logic                  out_image_done
);

  // A stalled span holds its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pixel_address)
      && $stable(out_span_length) && $stable(out_red) && $stable(out_alpha))
    else $error("stalled span changed");

  // Nothing is presented right after reset.
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("span valid after reset");

  // The image ends on row zero and closes the pixel that caused it.
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_image_done |-> out_span_last && out_row_index == 11'd0)
    else $error("image done off the top row or not last");

  // Spans are never empty and never longer than one packet.
  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_span_length != 8'd0 && out_span_length <= 8'd128)
    else $error("span length out of range");

endmodule

bind tga_pixel_stream_decoder tpsd_checker u_tpsd_checker (.*);
